@@ sv/sawr_pkg.sv @@
// ----------------------------------------------------------------------------
// sawr_pkg
// Types and constants shared by the serial audio word realigner modules.
// ----------------------------------------------------------------------------
package sawr_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int SCAN_BITS    = 10;

  localparam int WORD_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 10;
  localparam int TGT_W   = 2;

  // scan width and index limit are clamped to what the fixed fields hold
  localparam int SCAN_N    = (SCAN_BITS > WORD_W) ? WORD_W : SCAN_BITS;
  localparam int LIMIT_RAW = BUFFER_DEPTH - 1;
  localparam int LIMIT_INT = (LIMIT_RAW > 1023) ? 1023 : LIMIT_RAW;

  localparam logic [INDEX_W-1:0] IDX_LIMIT   = INDEX_W'(LIMIT_INT);
  localparam logic [COUNT_W-1:0] CALIB_WORDS = COUNT_W'(20);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(15);
  localparam logic [4:0]         SAMPLE_W5   = 5'(SAMPLE_BITS);

  localparam logic [TGT_W-1:0] TARGET_NONE = 2'd3;

  typedef enum logic {
    REG_BUFFER_TARGET = 1'b0,
    REG_CALIB_ENABLE  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CH_LEFT  = 1'b0,
    CH_RIGHT = 1'b1
  } channel_e;

  typedef struct packed {
    logic [WORD_W-1:0] serial_word;
    logic              lr_level;
    logic              rewind;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  sample;
    logic               channel;
    logic [TGT_W-1:0]   buffer_id;
    logic [INDEX_W-1:0] write_index;
  } out_item_t;

  typedef struct packed {
    logic [TGT_W-1:0] buffer_target;
    logic             calib_enable;
  } cfg_t;

endpackage

@@ sv/serial_audio_word_realigner.sv @@
// ----------------------------------------------------------------------------
// serial_audio_word_realigner
// Joins received serial words into audio samples on word select edges.
// ----------------------------------------------------------------------------
// Input channel: one transfer carries a 16-bit serial word, the word select
// level and a rewind flag. Output channel: a transfer carries the realigned
// sample, its channel (left on a rising select edge, right on a falling one),
// the buffer id and the running write index of that channel.
// Words without a select edge, words arriving while either index sits at the
// buffer limit, and words while no buffer is targeted give no output.
// An input transfer is captured in the input register; the realign stage
// computes the result from it combinationally, and the result is loaded
// into the result register. One word is accepted every cycle while
// in_stall_o is low.
// A stalled result is held in the result register; the input side keeps
// taking one more word into its register and then raises in_stall_o.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no transfer is in flight; only the user can ensure this.
// Reset clears all state and indices; buffer target resets to none, so no
// result appears until a buffer is selected.
// ----------------------------------------------------------------------------
module serial_audio_word_realigner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sawr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sawr_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  sawr_pkg::reg_idx_e  cfg_idx_i,
  input  logic [1:0]          cfg_wdata_i
);
  import sawr_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     item_take;

  sawr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sawr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  sawr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ sv/sawr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sawr_cfg_regs
// Configuration registers: buffer target and calibration enable.
// ----------------------------------------------------------------------------
module sawr_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  sawr_pkg::reg_idx_e   cfg_idx_i,
  input  logic [1:0]           cfg_wdata_i,
  output sawr_pkg::cfg_t       cfg_o
);
  import sawr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BUFFER_TARGET: cfg_d.buffer_target = cfg_wdata_i;
        REG_CALIB_ENABLE:  cfg_d.calib_enable  = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_target <= TARGET_NONE;
      cfg_q.calib_enable  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/sawr_in_stage.sv @@
// ----------------------------------------------------------------------------
// sawr_in_stage
// Input register: captures one word per transfer and holds it until the
// realign stage takes it.
// ----------------------------------------------------------------------------
module sawr_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sawr_pkg::in_item_t in_item_i,
  output logic               item_valid_o,
  output sawr_pkg::in_item_t item_o,
  input  logic               item_take_i
);
  import sawr_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // held word not taken this cycle blocks the next transfer
  assign in_stall_o = valid_q & ~item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ sv/sawr_core.sv @@
// ----------------------------------------------------------------------------
// sawr_core
// Realign stage: edge detect, sample join, shift calibration, write indices
// and the result register.
// ----------------------------------------------------------------------------
module sawr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sawr_pkg::cfg_t      cfg_i,
  input  logic                item_valid_i,
  input  sawr_pkg::in_item_t  item_i,
  output logic                item_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sawr_pkg::out_item_t out_item_o
);
  import sawr_pkg::*;

  logic               lr_prev_q, lr_prev_d;
  logic [WORD_W-1:0]  kept_q, kept_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [INDEX_W-1:0] left_q, left_d;
  logic [INDEX_W-1:0] right_q, right_d;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               rising, falling;
  logic [INDEX_W-1:0] left_cur, right_cur;
  logic [WORD_W-1:0]  lo_part, hi_part, sample;
  logic [4:0]         up_amt, dn_amt;
  logic [4:0]         top_pos;
  logic [SHIFT_W-1:0] top_sat;
  logic               calib_run;
  logic               room;
  logic               emit;
  logic               out_free;
  out_item_t          res;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign item_take_o = item_valid_i & out_free;

  assign rising  = item_i.lr_level & ~lr_prev_q;
  assign falling = ~item_i.lr_level & lr_prev_q;

  assign left_cur  = item_i.rewind ? '0 : left_q;
  assign right_cur = item_i.rewind ? '0 : right_q;

  // join new word with kept word at the current shift
  always_comb begin
    up_amt  = SAMPLE_W5 - {1'b0, shift_q};
    dn_amt  = {1'b0, shift_q} - SAMPLE_W5;
    lo_part = item_i.serial_word >> shift_q;
    if ({1'b0, shift_q} <= SAMPLE_W5) begin
      hi_part = kept_q << up_amt;
    end else begin
      hi_part = kept_q >> dn_amt;
    end
    sample = lo_part | hi_part;
  end

  assign kept_d = (rising | falling) ? kept_q : item_i.serial_word;

  // one past the highest set bit in the scanned low bits of the kept word
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < SCAN_N; i++) begin
      if (kept_d[i]) begin
        top_pos = 5'(i + 1);
      end
    end
    top_sat = (top_pos > {1'b0, SHIFT_MAX}) ? SHIFT_MAX : top_pos[SHIFT_W-1:0];
  end

  assign calib_run = cfg_i.calib_enable & (count_q < CALIB_WORDS);
  assign shift_d   = (calib_run && top_sat > shift_q) ? top_sat : shift_q;
  assign count_d   = calib_run ? count_q + 1'b1 : count_q;

  assign room = (left_cur < IDX_LIMIT) & (right_cur < IDX_LIMIT) &
                (cfg_i.buffer_target != TARGET_NONE);
  assign emit = room & (rising | falling);

  assign left_d    = (room && rising)  ? left_cur + 1'b1  : left_cur;
  assign right_d   = (room && falling) ? right_cur + 1'b1 : right_cur;
  assign lr_prev_d = item_i.lr_level;

  always_comb begin
    res.sample      = sample;
    res.channel     = rising ? CH_LEFT : CH_RIGHT;
    res.buffer_id   = cfg_i.buffer_target;
    res.write_index = rising ? left_cur : right_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_prev_q   <= 1'b0;
      kept_q      <= '0;
      shift_q     <= '0;
      count_q     <= '0;
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_take_o) begin
        lr_prev_q <= lr_prev_d;
        kept_q    <= kept_d;
        shift_q   <= shift_d;
        count_q   <= count_d;
        left_q    <= left_d;
        right_q   <= right_d;
      end
      if (out_free) begin
        out_valid_q <= item_take_o & emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/sawr_checker.sv @@
// ----------------------------------------------------------------------------
// sawr_checker
// Port-level checks for the serial audio word realigner, bound to the top.
// ----------------------------------------------------------------------------
module sawr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sawr_pkg::out_item_t out_item_o
);
  import sawr_pkg::*;

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled, occupied result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.buffer_id != TARGET_NONE)
    else $error("result sent with no buffer target");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.write_index < IDX_LIMIT)
    else $error("write index at or past buffer limit");

endmodule

bind serial_audio_word_realigner sawr_checker u_sawr_checker (.*);

@@ dv/serial_audio_word_realigner_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_audio_word_realigner_tb
// Self-checking bench for the serial audio word realigner.
// A behavioral predictor tracks select edges, the kept word, the alignment
// shift, calibration and both write indices, and queues the sample expected
// for each accepted word that yields an output. Every output transfer is
// checked against the oldest queued sample. Directed tests cover no target,
// field extremes, rewind, every buffer and calibration with its saturation;
// random phases follow with different input gap and output stall rates.
// ----------------------------------------------------------------------------
module serial_audio_word_realigner_tb;
  import sawr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  reg_idx_e  cfg_idx = REG_BUFFER_TARGET;
  logic [1:0] cfg_wdata = 2'd0;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // predictor state
  logic               pred_lr_prev;
  logic [WORD_W-1:0]  pred_kept;
  logic [SHIFT_W-1:0] pred_shift;
  logic [COUNT_W-1:0] pred_calib_cnt;
  logic [INDEX_W-1:0] pred_left_idx;
  logic [INDEX_W-1:0] pred_right_idx;
  logic [TGT_W-1:0]   pred_target;
  logic               pred_calib_en;

  out_item_t expected_samples[$];

  serial_audio_word_realigner u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic flag_error(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // result checker: each output transfer against the oldest expected sample
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        flag_error($sformatf("unexpected sample %h ch %0d buf %0d idx %0d",
                             out_item.sample, out_item.channel,
                             out_item.buffer_id, out_item.write_index));
      end else begin
        want = expected_samples.pop_front();
        if (out_item.sample !== want.sample || out_item.channel !== want.channel ||
            out_item.buffer_id !== want.buffer_id ||
            out_item.write_index !== want.write_index) begin
          flag_error($sformatf({"sample/ch/buf/idx exp %h/%0d/%0d/%0d ",
                                "got %h/%0d/%0d/%0d"},
                               want.sample, want.channel, want.buffer_id,
                               want.write_index, out_item.sample, out_item.channel,
                               out_item.buffer_id, out_item.write_index));
        end
      end
    end
  end

  // expected behavior for one accepted word
  task automatic realign_predict(input in_item_t w);
    logic      rising;
    logic      falling;
    logic [WORD_W-1:0] smp;
    out_item_t res;
    int sh;
    int lo;
    int hi;
    int i;
    int wdt;
    rising  = w.lr_level && !pred_lr_prev;
    falling = !w.lr_level && pred_lr_prev;
    smp = '0;
    sh = int'(pred_shift);
    if (w.rewind) begin
      pred_left_idx  = '0;
      pred_right_idx = '0;
    end
    if (rising || falling) begin
      lo = int'(w.serial_word) >> sh;
      if (sh <= SAMPLE_BITS) begin
        hi = (SAMPLE_BITS - sh >= 16) ? 0 : (int'(pred_kept) << (SAMPLE_BITS - sh));
      end else begin
        hi = (sh - SAMPLE_BITS >= 16) ? 0 : (int'(pred_kept) >> (sh - SAMPLE_BITS));
      end
      smp = WORD_W'(lo | hi);
    end else begin
      pred_kept = w.serial_word;
    end
    // calibration looks at the kept word after this word's update
    if (pred_calib_en && pred_calib_cnt < CALIB_WORDS) begin
      for (i = 0; i < SCAN_N; i++) begin
        if (pred_kept[i]) begin
          wdt = (i + 1 > int'(SHIFT_MAX)) ? int'(SHIFT_MAX) : i + 1;
          if (wdt > int'(pred_shift)) pred_shift = SHIFT_W'(wdt);
        end
      end
      pred_calib_cnt = pred_calib_cnt + 1'b1;
    end
    if ((rising || falling) && pred_left_idx < IDX_LIMIT && pred_right_idx < IDX_LIMIT &&
        pred_target != TARGET_NONE) begin
      res.sample    = smp;
      res.channel   = rising ? CH_LEFT : CH_RIGHT;
      res.buffer_id = pred_target;
      if (rising) begin
        res.write_index = pred_left_idx;
        pred_left_idx   = pred_left_idx + 1'b1;
      end else begin
        res.write_index = pred_right_idx;
        pred_right_idx  = pred_right_idx + 1'b1;
      end
      expected_samples.push_back(res);
    end
    pred_lr_prev = w.lr_level;
  endtask

  function automatic in_item_t mk_word(input logic [WORD_W-1:0] wd, input logic lvl,
                                       input logic rw);
    in_item_t it;
    it.serial_word = wd;
    it.lr_level    = lvl;
    it.rewind      = rw;
    return it;
  endfunction

  task automatic send_word(input in_item_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    realign_predict(w);
  endtask

  // stop sending, wait for all samples, then cover words still in flight
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [1:0] val);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_BUFFER_TARGET) pred_target = val;
    else pred_calib_en = val[0];
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic test_no_target();
    int k;
    write_reg(REG_BUFFER_TARGET, TARGET_NONE);
    write_reg(REG_CALIB_ENABLE, 2'd0);
    for (k = 0; k < 6; k++) send_word(mk_word(16'($urandom), k[0], 1'b0));
  endtask

  task automatic test_extremes();
    write_reg(REG_BUFFER_TARGET, 2'd0);
    send_word(mk_word(16'h0000, 1'b0, 1'b0));
    send_word(mk_word(16'hFFFF, 1'b1, 1'b0));
    send_word(mk_word(16'hFFFF, 1'b1, 1'b0));
    send_word(mk_word(16'h0000, 1'b0, 1'b0));
    send_word(mk_word(16'hA5A5, 1'b0, 1'b1));
    send_word(mk_word(16'h5A5A, 1'b1, 1'b0));
    send_word(mk_word(16'h8001, 1'b0, 1'b1));
    send_word(mk_word(16'h7FFE, 1'b1, 1'b1));
    send_word(mk_word(16'hFFFF, 1'b0, 1'b0));
  endtask

  task automatic test_targets();
    write_reg(REG_BUFFER_TARGET, 2'd1);
    send_word(mk_word(16'($urandom), 1'b1, 1'b0));
    send_word(mk_word(16'($urandom), 1'b0, 1'b0));
    write_reg(REG_BUFFER_TARGET, 2'd2);
    send_word(mk_word(16'($urandom), 1'b1, 1'b0));
    send_word(mk_word(16'($urandom), 1'b0, 1'b0));
  endtask

  // widen the shift below bit 9 in the first 20 words, then check that
  // later words with all low bits set no longer widen it
  task automatic test_calibration();
    int i;
    int top;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] wd;
    top  = $urandom_range(1, 9);
    mask = (16'h1 << top) - 1'b1;
    write_reg(REG_CALIB_ENABLE, 2'd1);
    for (i = 0; i < 26; i++) begin
      if (i < 20) begin
        wd = (16'($urandom) & ~16'h03FF) | (16'($urandom) & mask);
        if (i == 4) wd[top-1] = 1'b1;
      end else begin
        wd = 16'hFFFF;
      end
      send_word(mk_word(wd, 1'((i / 3) % 2), 1'b0));
    end
  endtask

  task automatic test_random(input int n_items, input int gap, input int stall,
                             input logic [1:0] tgt, input logic cal);
    int k;
    int run_left;
    logic lr;
    logic lvl;
    logic rw;
    write_reg(REG_BUFFER_TARGET, tgt);
    write_reg(REG_CALIB_ENABLE, {1'b0, cal});
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    lr = pred_lr_prev;
    run_left = 0;
    for (k = 0; k < n_items; k++) begin
      // mostly runs of kept words closed by a select edge, some noise
      if (run_left == 0) begin
        lr = ~lr;
        run_left = $urandom_range(1, 4);
      end
      run_left--;
      lvl = ($urandom_range(99) < 15) ? 1'($urandom) : lr;
      rw  = ($urandom_range(99) < 3);
      send_word(mk_word(16'($urandom), lvl, rw));
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  initial begin
    pred_lr_prev   = 1'b0;
    pred_kept      = '0;
    pred_shift     = '0;
    pred_calib_cnt = '0;
    pred_left_idx  = '0;
    pred_right_idx = '0;
    pred_target    = TARGET_NONE;
    pred_calib_en  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    send_gap_pct   = 15;
    recv_stall_pct = 72;
    test_no_target();
    test_extremes();
    test_targets();
    test_calibration();
    test_random(350, 15, 72, 2'd2, 1'b0);
    test_random(350, 72, 15, 2'd0, 1'b1);
    test_random(350, 0, 0, 2'd1, 1'b0);
    drain_results();
    repeat (10) @(posedge clk);
    if (expected_samples.size() != 0) begin
      flag_error($sformatf("%0d expected samples never arrived", expected_samples.size()));
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
